// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define QALU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define QALU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/qalu_pkg.sv
// shared widths, opcodes and the front end result type of the quaternion unit
package qalu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // truncated product, four-term sum, norm
  localparam int PROD_W    = 2 * WORD_BITS - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NORM_W    = PROD_W + 1;

  // digit-by-digit root
  localparam int ROOT_W    = WORD_BITS + 1;
  localparam int SQ_ITERS  = ROOT_W;
  localparam int SREM_W    = ROOT_W + 3;
  localparam int RAD_W     = 2 * ROOT_W;

  // restoring divider
  localparam int DIV_ITERS = WORD_BITS + 1;
  localparam int DREM_W    = NORM_W + 1;
  localparam int DVD_W     = SUM_W + FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_MUL  = 3'd1,
    OP_LDIV = 3'd2,
    OP_CONJ = 3'd3,
    OP_INV  = 3'd4,
    OP_NORM = 3'd5,
    OP_MAG  = 3'd6
  } op_e;

  // front end result: norm plus per-lane numerator or direct value
  typedef struct packed {
    op_e                     op;
    logic [NORM_W-1:0]       norm;
    logic [3:0][SUM_W-1:0]   lane;
  } front_t;

endpackage

// File: src/qalu_front.sv
// products, norm and lane sums of the quaternion unit (two stages)
module qalu_front (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  qalu_pkg::op_e                         op_i,
  input  logic [3:0][qalu_pkg::WORD_BITS-1:0]   a_i,
  input  logic [3:0][qalu_pkg::WORD_BITS-1:0]   b_i,
  output qalu_pkg::front_t                      res_o
);
  import qalu_pkg::*;

  // product shifted down, floor rounding
  function automatic logic [PROD_W-1:0] fmul(logic signed [WORD_BITS-1:0] x,
                                             logic signed [WORD_BITS-1:0] y);
    logic signed [2*WORD_BITS-1:0] p;
    p = x * y;
    return p[2*WORD_BITS-1:FRAC_BITS];
  endfunction

  logic [3:0][3:0][PROD_W-1:0] prod_q;
  logic [3:0][PROD_W-1:0]      sq_q;
  logic [3:0][WORD_BITS-1:0]   a_q, b_q;
  op_e                         op_q;
  front_t                      res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= fmul($signed(a_i[i]), $signed(b_i[j]));
        end
        sq_q[i] <= fmul($signed(a_i[i]), $signed(a_i[i]));
      end
      a_q  <= a_i;
      b_q  <= b_i;
      op_q <= op_i;
    end
  end

  logic signed [SUM_W-1:0] p [4][4];
  logic signed [SUM_W-1:0] av [4];
  logic signed [SUM_W-1:0] bv [4];
  logic signed [SUM_W-1:0] sqsum;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = SUM_W'($signed(prod_q[i][j]));
      end
      av[i] = SUM_W'($signed(a_q[i]));
      bv[i] = SUM_W'($signed(b_q[i]));
    end
    sqsum = SUM_W'($signed(sq_q[0])) + SUM_W'($signed(sq_q[1]))
          + SUM_W'($signed(sq_q[2])) + SUM_W'($signed(sq_q[3]));

    res_d.op   = op_q;
    res_d.norm = sqsum[NORM_W-1:0];
    res_d.lane = '0;
    case (op_q)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) res_d.lane[i] = av[i] + bv[i];
      end
      OP_MUL: begin
        res_d.lane[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
        res_d.lane[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
        res_d.lane[2] = p[0][2] - p[1][3] + p[2][0] + p[3][1];
        res_d.lane[3] = p[0][3] + p[1][2] - p[2][1] + p[3][0];
      end
      OP_LDIV: begin
        // conj(a) * b numerators
        res_d.lane[0] = p[0][0] + p[1][1] + p[2][2] + p[3][3];
        res_d.lane[1] = p[0][1] - p[1][0] - p[2][3] + p[3][2];
        res_d.lane[2] = p[0][2] + p[1][3] - p[2][0] - p[3][1];
        res_d.lane[3] = p[0][3] - p[1][2] + p[2][1] - p[3][0];
      end
      OP_CONJ, OP_INV: begin
        res_d.lane[0] = av[0];
        for (int i = 1; i < 4; i++) res_d.lane[i] = -av[i];
      end
      OP_NORM: begin
        for (int i = 0; i < 4; i++) res_d.lane[i] = av[i];
      end
      default: begin
        res_d.lane = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: src/quaternion_alu_top.sv
// quaternion unit top level: front end, root pipeline, divider pipeline, output skid
// throughput: one request per cycle while stall_o is low, every stage of the
// 69-stage pipe then taking a new one each cycle
// stall_o rises only when both the output register and the skid register are full
// reset clears all valid bits, those of the output register and the skid too; data is not reset
module quaternion_alu_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [2:0]        command_i,
  input  qalu_pkg::word_t   a_w_i,
  input  qalu_pkg::word_t   a_x_i,
  input  qalu_pkg::word_t   a_y_i,
  input  qalu_pkg::word_t   a_z_i,
  input  qalu_pkg::word_t   b_w_i,
  input  qalu_pkg::word_t   b_x_i,
  input  qalu_pkg::word_t   b_y_i,
  input  qalu_pkg::word_t   b_z_i,
  output logic              valid_o,
  input  logic              stall_i,
  output qalu_pkg::word_t   r_w_o,
  output qalu_pkg::word_t   r_x_o,
  output qalu_pkg::word_t   r_y_o,
  output qalu_pkg::word_t   r_z_o,
  output logic              error_o
);
  import qalu_pkg::*;

  // stage count: two front stages, root steps, divider set-up, divider steps
  localparam int FRONT_ST = 2;
  localparam int PIPE_ST  = FRONT_ST + SQ_ITERS + 1 + DIV_ITERS;

  // saturation bounds and overflow stand-ins at the sum width
  localparam logic signed [SUM_W-1:0] W_MAX =
    {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] W_MIN =
    {{(SUM_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] BIG_POS = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] BIG_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  // root pipeline stage
  typedef struct packed {
    op_e                    op;
    logic [NORM_W-1:0]      norm;
    logic [3:0][SUM_W-1:0]  lane;
    logic [ROOT_W-1:0]      root;
    logic [SREM_W-1:0]      srem;
  } root_t;

  // divider pipeline stage, four lanes sharing one divisor
  typedef struct packed {
    op_e                        op;
    logic                       zero;
    logic [3:0]                 neg;
    logic [3:0]                 ovf;
    logic [NORM_W-1:0]          den;
    logic [3:0][SUM_W-1:0]      lane;
    logic [3:0][DREM_W-1:0]     rem;
    logic [3:0][DIV_ITERS-1:0]  sh;
  } quo_t;

  // clamp to the word range, top bit flags saturation
  function automatic logic [WORD_BITS:0] satw(logic signed [SUM_W-1:0] v);
    if (v > W_MAX) return {1'b1, W_MAX[WORD_BITS-1:0]};
    if (v < W_MIN) return {1'b1, W_MIN[WORD_BITS-1:0]};
    return {1'b0, v[WORD_BITS-1:0]};
  endfunction

  // ---------------------------------------------------------------
  // pipeline advance: the whole pipe moves unless the skid is full
  // ---------------------------------------------------------------
  logic               en;
  logic [PIPE_ST-1:0] v_q;
  logic               ov_q, sv_q;

  assign en      = !sv_q;
  assign stall_o = sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_ST-2:0], valid_i};
    end
  end

  // ---------------------------------------------------------------
  // front end: products, norm and lane sums
  // ---------------------------------------------------------------
  front_t front;

  qalu_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_e'(command_i)),
    .a_i   ({a_z_i, a_y_i, a_x_i, a_w_i}),
    .b_i   ({b_z_i, b_y_i, b_x_i, b_w_i}),
    .res_o (front)
  );

  // ---------------------------------------------------------------
  // square root of norm scaled up by the fraction bits, one digit a stage
  // ---------------------------------------------------------------
  root_t rt_in [SQ_ITERS];
  root_t rt_q  [SQ_ITERS];

  for (genvar k = 0; k < SQ_ITERS; k++) begin : g_root
    localparam int PI = SQ_ITERS - 1 - k;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W+1:0] cur, trial;
    root_t             nxt;

    if (k == 0) begin : g_first
      assign rt_in[k] = '{op: front.op, norm: front.norm, lane: front.lane,
                          root: '0, srem: '0};
    end else begin : g_link
      assign rt_in[k] = rt_q[k-1];
    end

    always_comb begin
      nxt   = rt_in[k];
      rad   = RAD_W'({rt_in[k].norm, {FRAC_BITS{1'b0}}});
      cur   = {rt_in[k].srem, rad[2*PI+1 -: 2]};
      trial = (SREM_W+2)'({rt_in[k].root, 2'b01});
      if (cur >= trial) begin
        nxt.srem = SREM_W'(cur - trial);
        nxt.root = {rt_in[k].root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.srem = SREM_W'(cur);
        nxt.root = {rt_in[k].root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------
  // divider set-up: pick divisor, split sign, catch early overflow
  // ---------------------------------------------------------------
  root_t rs;
  quo_t  prep_d, prep_q;

  assign rs = rt_q[SQ_ITERS-1];

  always_comb begin
    logic signed [SUM_W-1:0] num;
    logic [SUM_W-1:0]        mag;
    logic [DVD_W-1:0]        dvd, hi;

    prep_d.op   = rs.op;
    prep_d.lane = rs.lane;
    // normalise divides by the magnitude, the rest by the norm
    if (rs.op == OP_NORM) begin
      prep_d.den = NORM_W'(rs.root);
    end else begin
      prep_d.den = rs.norm;
    end
    if (rs.op == OP_MAG) begin
      prep_d.lane    = '0;
      prep_d.lane[0] = SUM_W'(rs.root);
    end
    prep_d.zero = (prep_d.den == '0);
    for (int i = 0; i < 4; i++) begin
      num            = $signed(rs.lane[i]);
      prep_d.neg[i]  = num[SUM_W-1];
      mag            = prep_d.neg[i] ? SUM_W'(-num) : num;
      dvd            = {mag, {FRAC_BITS{1'b0}}};
      hi             = dvd >> DIV_ITERS;
      // quotient too large for the divider's bits: result saturates
      prep_d.ovf[i]  = (hi >= DVD_W'(prep_d.den));
      prep_d.rem[i]  = DREM_W'(hi);
      prep_d.sh[i]   = dvd[DIV_ITERS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  // ---------------------------------------------------------------
  // restoring divider, one quotient bit a stage on all four lanes
  // ---------------------------------------------------------------
  quo_t qu_in [DIV_ITERS];
  quo_t qu_q  [DIV_ITERS];

  for (genvar k = 0; k < DIV_ITERS; k++) begin : g_div
    quo_t nxt;

    if (k == 0) begin : g_first
      assign qu_in[k] = prep_q;
    end else begin : g_link
      assign qu_in[k] = qu_q[k-1];
    end

    always_comb begin
      logic [DREM_W:0] cur, den_x;
      logic            qbit;
      nxt   = qu_in[k];
      den_x = (DREM_W+1)'(qu_in[k].den);
      for (int i = 0; i < 4; i++) begin
        cur = {qu_in[k].rem[i], qu_in[k].sh[i][DIV_ITERS-1]};
        if (cur >= den_x) begin
          nxt.rem[i] = DREM_W'(cur - den_x);
          qbit       = 1'b1;
        end else begin
          nxt.rem[i] = DREM_W'(cur);
          qbit       = 1'b0;
        end
        nxt.sh[i] = {qu_in[k].sh[i][DIV_ITERS-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        qu_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------
  // result select, sign restore and saturation
  // ---------------------------------------------------------------
  quo_t                      fq;
  logic [3:0][WORD_BITS-1:0] res_d;
  logic                      err_d;

  assign fq = qu_q[DIV_ITERS-1];

  always_comb begin
    logic signed [SUM_W-1:0] lv, qx;
    logic [WORD_BITS:0]      s;
    err_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      lv = '0;
      qx = SUM_W'(fq.sh[i]);
      case (fq.op)
        OP_LDIV, OP_INV, OP_NORM: begin
          if (fq.zero) begin
            // zero divisor: lanes forced to zero
            lv    = '0;
            err_d = 1'b1;
          end else if (fq.ovf[i]) begin
            lv = fq.neg[i] ? BIG_NEG : BIG_POS;
          end else begin
            lv = fq.neg[i] ? -qx : qx;
          end
        end
        OP_ADD, OP_MUL, OP_CONJ, OP_MAG: begin
          lv = $signed(fq.lane[i]);
        end
        default: begin
          lv = '0;
        end
      endcase
      s        = satw(lv);
      res_d[i] = s[WORD_BITS-1:0];
      err_d    = err_d | s[WORD_BITS];
    end
  end

  // ---------------------------------------------------------------
  // output register plus skid: the pipe keeps moving while the consumer
  // stalls, until a spare request lands in the skid
  // ---------------------------------------------------------------
  logic [3:0][WORD_BITS-1:0] out_q, sk_q;
  logic                      oerr_q, skerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || !stall_i) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= v_q[PIPE_ST-1];
      end
    end else if (!sv_q && v_q[PIPE_ST-1]) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || !stall_i) begin
      if (sv_q) begin
        out_q  <= sk_q;
        oerr_q <= skerr_q;
      end else begin
        out_q  <= res_d;
        oerr_q <= err_d;
      end
    end else if (!sv_q) begin
      sk_q    <= res_d;
      skerr_q <= err_d;
    end
  end

  assign valid_o = ov_q;
  assign r_w_o   = out_q[0];
  assign r_x_o   = out_q[1];
  assign r_y_o   = out_q[2];
  assign r_z_o   = out_q[3];
  assign error_o = oerr_q;

endmodule

// File: src/qalu_checker.sv
// port-level checks of the quaternion unit and their bind
`include "assert_macros.svh"

module qalu_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             stall_o,
  input logic             valid_o,
  input logic             stall_i,
  input qalu_pkg::word_t  r_w_o,
  input qalu_pkg::word_t  r_x_o,
  input qalu_pkg::word_t  r_y_o,
  input qalu_pkg::word_t  r_z_o,
  input logic             error_o
);

  // a held result keeps every lane and the flag
  `QALU_ASSERT(a_out_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(r_w_o) && $stable(r_x_o) && $stable(r_y_o) && $stable(r_z_o) && $stable(error_o), "stalled result changed")

  // a full skid implies a full output register
  `QALU_ASSERT_ALWAYS(a_skid_out, clk_i, stall_o |-> valid_o, "input stalled with no result shown")

  // the skid only fills behind a stalled result
  `QALU_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(stall_o) |-> $past(valid_o && stall_i), "input stalled without output back-pressure")

endmodule

bind quaternion_alu_top qalu_checker u_qalu_checker (.*);
